[rtl/burg_pkg.sv]
// shared types and constants of the bounded uniform random generator
`timescale 1ns / 1ps

package burg_pkg;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned HALF_W   = 32;
    localparam int unsigned DIV_CNT_W = 7;

    localparam logic [DATA_W-1:0] GOLDEN_INC = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [DATA_W-1:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [DATA_W-1:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;
    localparam int unsigned MIX_SH_A = 30;
    localparam int unsigned MIX_SH_B = 27;
    localparam int unsigned MIX_SH_C = 31;

    typedef struct packed {
        logic [DATA_W-1:0] minimum;
        logic [DATA_W-1:0] maximum;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              range_error;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_LIMIT_START,
        ST_LIMIT_WAIT,
        ST_DRAW,
        ST_MA0,
        ST_MA1,
        ST_MA2,
        ST_MB0,
        ST_MB1,
        ST_MB2,
        ST_TEST,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic {
        DIV_LIMIT,
        DIV_MOD
    } div_kind_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_P0,
        MUL_P1,
        MUL_P2
    } mul_op_t;

    typedef enum logic {
        MUL_K_A,
        MUL_K_B
    } mul_k_t;

    typedef enum logic [1:0] {
        OUT_ERR,
        OUT_RAW,
        OUT_REM
    } out_sel_t;

    typedef struct packed {
        logic      capture;
        logic      prep;
        logic      div_start;
        div_kind_t div_kind;
        logic      limit_load;
        logic      advance;
        mul_op_t   mul_op;
        mul_k_t    mul_k;
        logic      load_out;
        out_sel_t  out_sel;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic full;
        logic div_busy;
        logic div_done;
        logic draw_ok;
        logic out_busy;
    } status_t;

endpackage

[rtl/burg_div.sv]
// radix-2 restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module burg_div
    import burg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DATA_W-1:0] rem
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    dvd_reg, dvd_next;
    logic [DATA_W-1:0]    dsr_reg, dsr_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W:0]      trial;
    logic [DATA_W:0]      diff;

    assign trial = {rem_reg, dvd_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DATA_W);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // keep the partial remainder when the trial subtract borrows
            rem_next = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/burg_dpath.sv]
// datapath: counter, mixer with shared 32x32 multiplier, divider, output register
`timescale 1ns / 1ps

module burg_dpath
    import burg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output status_t           status,
    input  req_t              s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rsp_t              m_data,
    input  logic              cfg_we,
    input  logic [DATA_W-1:0] cfg_data
);

    logic [DATA_W-1:0] counter_reg, counter_next;
    logic [DATA_W-1:0] lo_reg, hi_reg;
    logic [DATA_W-1:0] w_reg, limit_reg;
    logic              err_reg, full_reg;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              m_valid_reg;
    rsp_t              m_data_reg;

    logic [DATA_W-1:0] mul_k_val;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [DATA_W-1:0] mul_p;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] div_dividend;
    logic              div_busy, div_done;
    logic [DATA_W-1:0] div_rem;

    assign counter_next = counter_reg + GOLDEN_INC;
    assign mul_k_val    = (cmd.mul_k == MUL_K_A) ? MIX_MUL_A : MIX_MUL_B;

    // low 64 bits of x * k from three 32-bit partial products
    always_comb begin
        case (cmd.mul_op)
            MUL_P0: begin
                mul_a = x_reg[HALF_W-1:0];
                mul_b = mul_k_val[HALF_W-1:0];
            end
            MUL_P1: begin
                mul_a = x_reg[HALF_W-1:0];
                mul_b = mul_k_val[DATA_W-1:HALF_W];
            end
            MUL_P2: begin
                mul_a = x_reg[DATA_W-1:HALF_W];
                mul_b = mul_k_val[HALF_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign sum   = acc_reg + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};

    always_comb begin
        x_next   = x_reg;
        acc_next = acc_reg;
        if (cmd.advance) begin
            x_next = counter_next ^ (counter_next >> MIX_SH_A);
        end
        case (cmd.mul_op)
            MUL_P0: acc_next = mul_p;
            MUL_P1: acc_next = sum;
            MUL_P2: begin
                if (cmd.mul_k == MUL_K_A) begin
                    x_next = sum ^ (sum >> MIX_SH_B);
                end else begin
                    x_next = sum ^ (sum >> MIX_SH_C);
                end
            end
            default: acc_next = acc_reg;
        endcase
    end

    assign div_dividend = (cmd.div_kind == DIV_LIMIT) ? (DATA_W'(0) - w_reg) : x_reg;

    burg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (w_reg),
        .busy     (div_busy),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                counter_reg <= cfg_data;
            end else if (cmd.advance) begin
                counter_reg <= counter_next;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (cmd.capture) begin
            lo_reg <= s_data.minimum;
            hi_reg <= s_data.maximum;
        end
        if (cmd.prep) begin
            err_reg   <= lo_reg > hi_reg;
            full_reg  <= (lo_reg == '0) && (hi_reg == '1);
            w_reg     <= hi_reg - lo_reg + 1'b1;
            limit_reg <= '0;
        end else if (cmd.limit_load) begin
            limit_reg <= div_rem;
        end
        x_reg   <= x_next;
        acc_reg <= acc_next;
        if (cmd.load_out) begin
            case (cmd.out_sel)
                OUT_ERR: begin
                    m_data_reg.value       <= '0;
                    m_data_reg.range_error <= 1'b1;
                end
                OUT_RAW: begin
                    m_data_reg.value       <= x_reg;
                    m_data_reg.range_error <= 1'b0;
                end
                OUT_REM: begin
                    m_data_reg.value       <= lo_reg + div_rem;
                    m_data_reg.range_error <= 1'b0;
                end
                default: begin
                    m_data_reg.value       <= '0;
                    m_data_reg.range_error <= 1'b1;
                end
            endcase
        end
    end

    assign status.err      = err_reg;
    assign status.full     = full_reg;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.draw_ok  = x_reg >= limit_reg;
    assign status.out_busy = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/burg_ctrl.sv]
// controller state machine sequencing draws, mixing and divisions
`timescale 1ns / 1ps

module burg_ctrl
    import burg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: state_next = ST_LIMIT_START;
            ST_LIMIT_START: begin
                if (status.err) begin
                    state_next = ST_OUT;
                end else if (status.full) begin
                    state_next = ST_DRAW;
                end else begin
                    state_next = ST_LIMIT_WAIT;
                end
            end
            ST_LIMIT_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: state_next = ST_MA0;
            ST_MA0:  state_next = ST_MA1;
            ST_MA1:  state_next = ST_MA2;
            ST_MA2:  state_next = ST_MB0;
            ST_MB0:  state_next = ST_MB1;
            ST_MB1:  state_next = ST_MB2;
            ST_MB2:  state_next = ST_TEST;
            ST_TEST: begin
                if (!status.draw_ok) begin
                    state_next = ST_DRAW;
                end else if (status.full) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MOD_START;
                end
            end
            ST_MOD_START: state_next = ST_MOD_WAIT;
            ST_MOD_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.div_kind = DIV_LIMIT;
        cmd.mul_op   = MUL_NONE;
        cmd.mul_k    = MUL_K_A;
        cmd.out_sel  = OUT_ERR;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_PREP: cmd.prep = 1'b1;
            ST_LIMIT_START: begin
                cmd.div_start = !status.err && !status.full;
            end
            ST_LIMIT_WAIT: cmd.limit_load = status.div_done;
            ST_DRAW: cmd.advance = 1'b1;
            ST_MA0:  cmd.mul_op = MUL_P0;
            ST_MA1:  cmd.mul_op = MUL_P1;
            ST_MA2:  cmd.mul_op = MUL_P2;
            ST_MB0: begin
                cmd.mul_op = MUL_P0;
                cmd.mul_k  = MUL_K_B;
            end
            ST_MB1: begin
                cmd.mul_op = MUL_P1;
                cmd.mul_k  = MUL_K_B;
            end
            ST_MB2: begin
                cmd.mul_op = MUL_P2;
                cmd.mul_k  = MUL_K_B;
            end
            ST_MOD_START: begin
                cmd.div_start = 1'b1;
                cmd.div_kind  = DIV_MOD;
            end
            ST_OUT: begin
                cmd.load_out = !status.out_busy;
                if (status.err) begin
                    cmd.out_sel = OUT_ERR;
                end else if (status.full) begin
                    cmd.out_sel = OUT_RAW;
                end else begin
                    cmd.out_sel = OUT_REM;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // an accepted request always starts with range preparation
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_PREP))
        else $error("accepted request did not enter preparation");

    // the result register is never overwritten while it still holds a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !status.out_busy)
        else $error("result loaded over a pending transaction");

    // a division is never started on top of a running one
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divider restarted while busy");

    // an empty range goes straight to the result without drawing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIMIT_START && status.err) |=> (state_reg == ST_OUT))
        else $error("range error did not skip the draw");
`endif

endmodule

[rtl/bounded_uniform_random_generator_top.sv]
// top level of the bounded uniform random generator
`timescale 1ns / 1ps

// bounded uniform random generator: each request transaction carries a
// minimum and a maximum, and one result transaction comes back with a
// splitmix64 value drawn uniformly from the closed range, or value 0 with
// range_error set when the minimum is above the maximum (the counter then
// stays put). writing cfg_data with cfg_we high reloads the 64-bit counter;
// write only while no request is in flight. one request is worked at a time.
// a normal range runs, from one accepted request to the next: setup
// (accept, range prep, divider start), the 64-step radix-2 remainder that
// gives the rejection threshold, a draw (counter step plus two 64-bit
// multiplies built from three 32x32 partial products each, then the
// threshold test), a second 64-step remainder on the shared divider, and
// the load of the result; each rejected draw is followed by a new draw.
// the full 64-bit range skips both divisions, and a range error skips the
// divisions and the draws. the result sits in an output register, so
// s_ready comes back as soon as it is loaded.

module bounded_uniform_random_generator_top
    import burg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  req_t              s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output rsp_t              m_data,
    // seed register write port
    input  logic              cfg_we,
    input  logic [DATA_W-1:0] cfg_data
);

    // command and status between the sequencer and the datapath
    cmd_t    cmd;
    status_t status;

    burg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    burg_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

endmodule
